// ===== rtl/core/swks_pkg.sv =====
package swks_pkg;

   localparam int MAX_WINDOW  = 64;
   localparam int SAMPLE_BITS = 32;

   localparam int IDX_BITS  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int LEN_BITS  = $clog2(MAX_WINDOW + 1);
   localparam int CFG_BITS  = 7;
   localparam int WIDE_BITS = (LEN_BITS > CFG_BITS) ? LEN_BITS : CFG_BITS;
   localparam int CSR_IDX_BITS = 2;
   localparam int DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

   localparam logic [CSR_IDX_BITS-1:0] REG_WINDOW_LENGTH = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] REG_RANK          = CSR_IDX_BITS'(1);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [IDX_BITS-1:0]           idx_type;
   typedef logic [LEN_BITS-1:0]           len_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_SEND
   } state_type;

   // control broadcast to every cell of the chain
   typedef struct packed {
      logic    shift;
      logic    load;
      logic    scan;
      len_type len;
      idx_type rank_m1;
   } cell_ctrl_type;

   // clamp a register value to 1..MAX_WINDOW
   function automatic len_type clamp_len(input logic [CFG_BITS-1:0] v);
      logic [WIDE_BITS-1:0] w;
      w = WIDE_BITS'(v);
      if (w == '0) begin
         w = WIDE_BITS'(1);
      end else if (w > WIDE_BITS'(MAX_WINDOW)) begin
         w = WIDE_BITS'(MAX_WINDOW);
      end
      return w[LEN_BITS-1:0];
   endfunction

endpackage

// ===== rtl/core/swks_cell.sv =====
module swks_cell (
   input  logic                  clock,
   input  swks_pkg::idx_type     idx,
   input  swks_pkg::cell_ctrl_type ctrl,
   input  swks_pkg::sample_type  shift_in,
   input  swks_pkg::sample_type  travel_in,
   input  swks_pkg::idx_type     tag_in,
   output swks_pkg::sample_type  sample_out,
   output swks_pkg::sample_type  travel_out,
   output swks_pkg::idx_type     tag_out,
   output logic                  hit
);
   import swks_pkg::*;

   sample_type value_ff, value_in;
   sample_type travel_ff, travel_in_nxt;
   idx_type    tag_ff, tag_in_nxt;
   idx_type    count_ff, count_in;
   logic       below;
   logic       tag_live;

   // visiting sample ranks below ours; ties go to the younger slot
   assign below    = (travel_ff < value_ff) || ((travel_ff == value_ff) && (tag_ff < idx));
   assign tag_live = LEN_BITS'(tag_ff) < ctrl.len;

   always_comb begin
      value_in      = value_ff;
      travel_in_nxt = travel_ff;
      tag_in_nxt    = tag_ff;
      count_in      = count_ff;
      if (ctrl.shift) begin
         value_in = shift_in;
      end
      if (ctrl.load) begin
         travel_in_nxt = value_ff;
         tag_in_nxt    = idx;
         count_in      = '0;
      end else if (ctrl.scan) begin
         travel_in_nxt = travel_in;
         tag_in_nxt    = tag_in;
         if (below && tag_live) begin
            count_in = count_ff + idx_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      travel_ff <= travel_in_nxt;
      tag_ff    <= tag_in_nxt;
      count_ff  <= count_in;
   end

   assign sample_out = value_ff;
   assign travel_out = travel_ff;
   assign tag_out    = tag_ff;
   assign hit        = (LEN_BITS'(idx) < ctrl.len) && (count_ff == ctrl.rank_m1);

endmodule

// ===== rtl/core/sliding_window_kth_smallest_core.sv =====
// channel  direction  handshake              payload
// req      in         req_tvalid/req_tready  req_tdata[31:0]  sample
// rsp      out        rsp_tvalid/rsp_tready  rsp_tdata[31:0]  rank_value
// csr      in         csr_we                 csr_index, csr_wdata
//
// A sample that does not complete the window leaves the block ready for the
// next. A sample that yields a result is shifted in; then the ring is seeded,
// the comparison ring makes a full revolution through the cell chain, and the
// result goes to the output register; no new sample is taken until then.
// Reset is synchronous and clears control and config; the sample chain needs
// no clearing. A stalled result holds in the output register while the next
// sample is taken; a finished scan then waits only if that register is still full.
module sliding_window_kth_smallest_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [swks_pkg::DATA_BITS-1:0]       req_tdata,   // [31:0] sample
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [swks_pkg::DATA_BITS-1:0]       rsp_tdata,   // [31:0] rank_value
   input  logic                                 csr_we,
   input  logic [swks_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [swks_pkg::CFG_BITS-1:0]        csr_wdata
);
   import swks_pkg::*;

   state_type             state_ff, state_in;
   logic [CFG_BITS-1:0]   len_cfg_ff, len_cfg_in;
   logic [CFG_BITS-1:0]   rank_cfg_ff, rank_cfg_in;
   len_type               fill_ff, fill_in;
   idx_type               step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   sample_type            rsp_data_ff, rsp_data_in;

   len_type               len_eff;
   len_type               rank_sat;
   len_type               rank_eff;
   cell_ctrl_type         ctrl;
   logic                  accept;
   sample_type            pick;

   sample_type            chain [MAX_WINDOW];
   sample_type            travel [MAX_WINDOW];
   idx_type               tag [MAX_WINDOW];
   logic [MAX_WINDOW-1:0] hit;

   assign len_eff  = clamp_len(len_cfg_ff);
   assign rank_sat = clamp_len(rank_cfg_ff);
   assign rank_eff = (rank_sat > len_eff) ? len_eff : rank_sat;

   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      ctrl.shift   = accept;
      ctrl.load    = (state_ff == ST_LOAD);
      ctrl.scan    = (state_ff == ST_SCAN);
      ctrl.len     = len_eff;
      ctrl.rank_m1 = IDX_BITS'(rank_eff - len_type'(1));
   end

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      localparam int PREV = (i == 0) ? MAX_WINDOW - 1 : i - 1;
      sample_type shift_src;
      if (i == 0) begin : g_head
         assign shift_src = sample_type'(req_tdata[SAMPLE_BITS-1:0]);
      end else begin : g_body
         assign shift_src = chain[i-1];
      end
      swks_cell u_cell (
         .clock      (clock),
         .idx        (IDX_BITS'(i)),
         .ctrl       (ctrl),
         .shift_in   (shift_src),
         .travel_in  (travel[PREV]),
         .tag_in     (tag[PREV]),
         .sample_out (chain[i]),
         .travel_out (travel[i]),
         .tag_out    (tag[i]),
         .hit        (hit[i])
      );
   end

   // exactly one cell holds the wanted rank once the scan is done
   always_comb begin
      pick = '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
         pick = pick | (chain[i] & {SAMPLE_BITS{hit[i]}});
      end
   end

   always_comb begin
      state_in     = state_ff;
      len_cfg_in   = len_cfg_ff;
      rank_cfg_in  = rank_cfg_ff;
      fill_in      = fill_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_we) begin
         case (csr_index)
            REG_WINDOW_LENGTH: len_cfg_in  = csr_wdata;
            REG_RANK:          rank_cfg_in = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (fill_ff < len_type'(MAX_WINDOW)) begin
                  fill_in = fill_ff + len_type'(1);
               end
               if (fill_in >= len_eff) begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            step_in  = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            step_in = step_ff + idx_type'(1);
            if (step_ff == idx_type'(MAX_WINDOW - 1)) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pick;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_cfg_ff   <= CFG_BITS'(64);
         rank_cfg_ff  <= CFG_BITS'(1);
         fill_ff      <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_cfg_ff   <= len_cfg_in;
         rank_cfg_ff  <= rank_cfg_in;
         fill_ff      <= fill_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_BITS'(unsigned'(rsp_data_ff));

endmodule

// ===== tb/rank_filter_checker.sv =====
`timescale 1ns / 100ps

module rank_filter_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [swks_pkg::DATA_BITS-1:0]    req_tdata,   // [31:0] sample
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [swks_pkg::DATA_BITS-1:0]    rsp_tdata,   // [31:0] rank_value
   input  logic                              csr_we,
   input  logic [swks_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [swks_pkg::CFG_BITS-1:0]     csr_wdata,
   output int                                mismatch_count,
   output int                                in_flight
);
   import swks_pkg::*;

   sample_type          history [MAX_WINDOW];
   idx_type             write_slot;
   int                  received;
   logic [CFG_BITS-1:0] window_reg;
   logic [CFG_BITS-1:0] rank_reg;
   sample_type          expected_ranks [$];
   int                  fails = 0;

   function automatic int clamp_to(input int v, input int upper);
      if (v < 1) begin
         return 1;
      end
      if (v > upper) begin
         return upper;
      end
      return v;
   endfunction

   // insertion sort of the latest wlen samples, newest first
   function automatic sample_type kth_smallest(input int wlen, input int k);
      sample_type sorted [MAX_WINDOW];
      sample_type v;
      idx_type    slot;
      int         j;
      slot = write_slot;
      for (int i = 0; i < wlen; i++) begin
         slot = slot - 1'b1;
         v = history[slot];
         j = i;
         while (j > 0 && sorted[j-1] > v) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = v;
      end
      return sorted[k-1];
   endfunction

   function automatic void flag(input string msg);
      fails++;
      if (fails <= 10) begin
         $display("[%0t] %s", $time, msg);
      end
   endfunction

   always @(posedge clock) begin : monitor
      int         wlen;
      int         k;
      sample_type got;
      sample_type want;
      if (reset) begin
         write_slot = '0;
         received   = 0;
         window_reg = CFG_BITS'(MAX_WINDOW);
         rank_reg   = CFG_BITS'(1);
         expected_ranks.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_WINDOW_LENGTH: window_reg = csr_wdata;
               REG_RANK:          rank_reg = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            history[write_slot] = sample_type'(req_tdata[SAMPLE_BITS-1:0]);
            write_slot = write_slot + 1'b1;
            if (received < MAX_WINDOW) begin
               received++;
            end
            wlen = clamp_to(int'(window_reg), MAX_WINDOW);
            k    = clamp_to(int'(rank_reg), wlen);
            if (received >= wlen) begin
               expected_ranks.push_back(kth_smallest(wlen, k));
            end
         end
         if (rsp_tvalid === 1'b1 && rsp_tready) begin
            got = sample_type'(rsp_tdata[SAMPLE_BITS-1:0]);
            if (expected_ranks.size() == 0) begin
               flag($sformatf("rank_value %0d arrived with no result pending", got));
            end else begin
               want = expected_ranks.pop_front();
               if (got !== want) begin
                  flag($sformatf("rank_value mismatch: expected %0d, got %0d", want, got));
               end
            end
         end
      end
      mismatch_count <= fails;
      in_flight      <= expected_ranks.size();
   end

endmodule

// ===== tb/tb_sliding_window_kth_smallest_core.sv =====
`timescale 1ns / 100ps

module tb_sliding_window_kth_smallest_core;
   import swks_pkg::*;

   localparam int CYCLE_LIMIT   = 600_000;
   localparam int SETTLE_CYCLES = MAX_WINDOW + 16;
   localparam int SEGMENTS      = 12;
   localparam int SEGMENT_ITEMS = 79;

   localparam logic [CSR_IDX_BITS-1:0] REG_SPARE_A = CSR_IDX_BITS'(2);
   localparam logic [CSR_IDX_BITS-1:0] REG_SPARE_B = CSR_IDX_BITS'(3);

   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [DATA_BITS-1:0]    req_tdata  = '0;   // [31:0] sample
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [DATA_BITS-1:0]    rsp_tdata;         // [31:0] rank_value
   logic                    csr_we     = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index  = '0;
   logic [CFG_BITS-1:0]     csr_wdata  = '0;

   int mismatch_count;
   int in_flight;
   int cycles       = 0;
   int send_gap_pct = 27;
   int recv_gap_pct = 65;

   sliding_window_kth_smallest_core u_dut (.*);

   rank_filter_checker u_checker (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_gap_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("** sliding_window_kth_smallest_core: FAILED **");
         $finish;
      end
   end

   // leaves csr_we high so back-to-back writes need no gap
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CFG_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [CFG_BITS-1:0] wl, input logic [CFG_BITS-1:0] rk);
      write_reg(REG_WINDOW_LENGTH, wl);
      write_reg(REG_RANK, rk);
      csr_we <= 1'b0;
   endtask

   // returns on the accepting edge with valid still high
   task automatic send_sample(input sample_type s);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= DATA_BITS'($unsigned(s));
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (in_flight != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [CFG_BITS-1:0] random_setting();
      if ($urandom_range(3) == 0) begin
         return CFG_BITS'($urandom_range((1 << CFG_BITS) - 1));
      end
      return CFG_BITS'($urandom_range(1, MAX_WINDOW));
   endfunction

   // narrow values give plenty of ties in the window
   function automatic sample_type random_sample();
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(3))
               0:       return SAMPLE_MIN;
               1:       return SAMPLE_MAX;
               2:       return '0;
               default: return -1;
            endcase
         end
         1, 2, 3: return sample_type'(int'($urandom_range(8)) - 4);
         default: return sample_type'($urandom());
      endcase
   endfunction

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero window and zero rank both act as one: every beat echoes back
      set_config('0, '0);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_sample('0);
      send_sample(-1);
      send_sample(1);
      drain();

      // spare indexes must not touch the registers
      write_reg(REG_SPARE_A, CFG_BITS'(2));
      write_reg(REG_SPARE_B, CFG_BITS'(2));
      // rank past the window gives the max; window reaches back into old beats
      set_config(CFG_BITS'(3), CFG_BITS'(127));
      send_sample(17);
      send_sample(SAMPLE_MIN);
      send_sample(-3);
      send_sample(2);
      drain();

      set_config(CFG_BITS'(4), CFG_BITS'(2));
      send_sample(5);
      send_sample(5);
      send_sample(-5);
      send_sample(-5);
      drain();

      // both saturate to the full window, which is not filled yet
      set_config(CFG_BITS'(65), CFG_BITS'(65));
      repeat (8) send_sample(random_sample());

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain();
         if (seg == SEGMENTS / 3) begin
            send_gap_pct = 65;
            recv_gap_pct = 27;
         end else if (seg == 2 * SEGMENTS / 3) begin
            send_gap_pct = 0;
            recv_gap_pct = 0;
         end
         case (seg)
            0:       set_config(CFG_BITS'(MAX_WINDOW), CFG_BITS'(1));
            1:       set_config(CFG_BITS'(MAX_WINDOW), CFG_BITS'(MAX_WINDOW));
            2:       set_config(CFG_BITS'(127), '0);
            3:       set_config(CFG_BITS'(2), CFG_BITS'(2));
            default: set_config(random_setting(), random_setting());
         endcase
         repeat (SEGMENT_ITEMS) send_sample(random_sample());
      end
      drain();

      if (mismatch_count == 0 && in_flight == 0) begin
         $display("** sliding_window_kth_smallest_core: PASSED **");
      end else begin
         $display("** sliding_window_kth_smallest_core: FAILED **");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/swks_pkg.sv
rtl/core/swks_cell.sv
rtl/core/sliding_window_kth_smallest_core.sv
tb/rank_filter_checker.sv
tb/tb_sliding_window_kth_smallest_core.sv
